// File: rtl/core/tsc_pkg.sv
package tsc_pkg;

  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned GEST_W  = 3;

  localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

  localparam logic [CODE_W-1:0] CODE_X        = 10'd0;
  localparam logic [CODE_W-1:0] CODE_Y        = 10'd1;
  localparam logic [CODE_W-1:0] CODE_PRESSURE = 10'd24;
  localparam logic [CODE_W-1:0] CODE_TOUCH    = 10'd330;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_TAP_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_UNDO_LEFT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_UNDO_TOP      = 3'd2;
  localparam logic [IDX_W-1:0] REG_UNDO_WIDTH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_UNDO_HEIGHT   = 3'd4;

  localparam logic [CFG_W-1:0] TAP_THRESHOLD_RESET = 16'd20;

  typedef enum logic [GEST_W-1:0] {
    G_UNDO    = 3'd0,
    G_RESTART = 3'd1,
    G_RIGHT   = 3'd2,
    G_LEFT    = 3'd3,
    G_DOWN    = 3'd4,
    G_UP      = 3'd5
  } gesture_t;

  typedef struct packed {
    logic [CFG_W-1:0] tap_threshold;
    logic [CFG_W-1:0] undo_left;
    logic [CFG_W-1:0] undo_top;
    logic [CFG_W-1:0] undo_width;
    logic [CFG_W-1:0] undo_height;
  } cfg_t;

endpackage

// File: rtl/core/tsc_if.sv
interface tsc_event_if;
  logic                                  valid;
  logic                                  ready;
  logic        [tsc_pkg::TYPE_W-1:0]     event_type;
  logic        [tsc_pkg::CODE_W-1:0]     event_code;
  logic signed [tsc_pkg::VALUE_W-1:0]    event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tsc_gesture_if;
  logic                         valid;
  logic                         ready;
  logic [tsc_pkg::GEST_W-1:0]   gesture;

  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

interface tsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsc_pkg::IDX_W-1:0]   index;
  logic [tsc_pkg::CFG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/touch_swipe_classifier.sv
// channel  dir  payload                                  request moved
// evt      in   event_type[4:0] event_code[9:0]          one input event
//               event_value[31:0] signed
// res      out  gesture[2:0]                             one gesture
// cfg      in   index[2:0] data[15:0]                    one register write
//
// One event is taken per cycle unless the result stalls; the input register
// feeds the state update and classifier, and the result register takes the
// gesture of a release. cfg.ready is always high. rst is synchronous and
// clears the gesture state and the result valid. A stalled result holds the
// input register, which still takes one more event before evt.ready drops.
module touch_swipe_classifier (
  input  logic           clk,
  input  logic           rst,
  tsc_event_if.sink      evt,
  tsc_gesture_if.source  res,
  tsc_cfg_if.sink        cfg
);
  import tsc_pkg::*;

  cfg_t regs;

  tsc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .evt  (evt),
    .res  (res)
  );

endmodule

// File: rtl/core/tsc_cfg_regs.sv
module tsc_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  tsc_cfg_if.sink            cfg,
  output tsc_pkg::cfg_t      regs
);
  import tsc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tap_threshold <= TAP_THRESHOLD_RESET;
      regs.undo_left     <= '0;
      regs.undo_top      <= '0;
      regs.undo_width    <= '0;
      regs.undo_height   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TAP_THRESHOLD: regs.tap_threshold <= cfg.data;
        REG_UNDO_LEFT:     regs.undo_left     <= cfg.data;
        REG_UNDO_TOP:      regs.undo_top      <= cfg.data;
        REG_UNDO_WIDTH:    regs.undo_width    <= cfg.data;
        REG_UNDO_HEIGHT:   regs.undo_height   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tsc_core.sv
module tsc_core (
  input  logic               clk,
  input  logic               rst,
  input  tsc_pkg::cfg_t      regs,
  tsc_event_if.sink          evt,
  tsc_gesture_if.source      res
);
  import tsc_pkg::*;

  // input stage
  logic                      s1_valid;
  logic [TYPE_W-1:0]         s1_type;
  logic [CODE_W-1:0]         s1_code;
  logic signed [VALUE_W-1:0] s1_value;

  // gesture state
  logic [COORD_W-1:0] start_x, start_y, last_x, last_y;
  logic               x_started, y_started;
  logic [COORD_W-1:0] start_x_next, start_y_next, last_x_next, last_y_next;
  logic               x_started_next, y_started_next;

  // result register
  logic               out_valid;
  logic               out_valid_next;
  gesture_t           out_gesture;

  logic               advance;
  logic               is_x, is_y, release_ev, emit;
  logic [COORD_W-1:0] coord;
  logic [COORD_W-1:0] dx, dy;
  logic               tap, in_rect, swipe_x, swipe_y;
  gesture_t           g;

  assign advance   = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_type  <= evt.event_type;
      s1_code  <= evt.event_code;
      s1_value <= evt.event_value;
    end
  end

  always_comb begin
    is_x = (s1_type == EV_ABS) && (s1_code == CODE_X);
    is_y = (s1_type == EV_ABS) && (s1_code == CODE_Y);
    // clamp to 0..65535
    if (s1_value[VALUE_W-1])
      coord = '0;
    else if (|s1_value[VALUE_W-2:COORD_W])
      coord = '1;
    else
      coord = s1_value[COORD_W-1:0];

    release_ev = (s1_value == '0) &&
                 (((s1_type == EV_KEY) && (s1_code == CODE_TOUCH)) ||
                  ((s1_type == EV_ABS) && (s1_code == CODE_PRESSURE)));

    // release events never touch the coordinates, so current state is used
    if (!x_started)          dx = '0;
    else if (last_x > start_x) dx = last_x - start_x;
    else                     dx = start_x - last_x;
    if (!y_started)          dy = '0;
    else if (last_y > start_y) dy = last_y - start_y;
    else                     dy = start_y - last_y;

    tap = (dx < regs.tap_threshold) && (dy < regs.tap_threshold);
    in_rect = x_started && y_started &&
              (start_x >= regs.undo_left) &&
              ({1'b0, start_x} < ({1'b0, regs.undo_left} + {1'b0, regs.undo_width})) &&
              (start_y >= regs.undo_top) &&
              ({1'b0, start_y} < ({1'b0, regs.undo_top} + {1'b0, regs.undo_height}));
    swipe_x = {1'b0, dx} >= {dy, 1'b0};
    swipe_y = {1'b0, dy} >= {dx, 1'b0};

    if (tap)
      g = in_rect ? G_UNDO : G_RESTART;
    else if (swipe_x)
      g = (x_started && (last_x > start_x)) ? G_RIGHT : G_LEFT;
    else
      g = (y_started && (last_y > start_y)) ? G_DOWN : G_UP;

    emit = release_ev && (tap || swipe_x || swipe_y);
  end

  always_comb begin
    start_x_next   = start_x;
    start_y_next   = start_y;
    last_x_next    = last_x;
    last_y_next    = last_y;
    x_started_next = x_started;
    y_started_next = y_started;
    if (advance) begin
      if (is_x) begin
        if (!x_started) begin
          start_x_next   = coord;
          x_started_next = 1'b1;
        end
        last_x_next = coord;
      end
      if (is_y) begin
        if (!y_started) begin
          start_y_next   = coord;
          y_started_next = 1'b1;
        end
        last_y_next = coord;
      end
      if (release_ev) begin
        // ambiguous swipe keeps the latest points, a result clears all
        start_x_next   = '0;
        start_y_next   = '0;
        x_started_next = 1'b0;
        y_started_next = 1'b0;
        if (emit) begin
          last_x_next = '0;
          last_y_next = '0;
        end
      end
    end
    out_valid_next = (out_valid && !res.ready) || (advance && emit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      last_x    <= '0;
      last_y    <= '0;
      x_started <= 1'b0;
      y_started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_x   <= start_x_next;
      start_y   <= start_y_next;
      last_x    <= last_x_next;
      last_y    <= last_y_next;
      x_started <= x_started_next;
      y_started <= y_started_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_gesture <= g;
    end
  end

  assign res.valid   = out_valid;
  assign res.gesture = out_gesture;

endmodule

// File: verif/touch_swipe_classifier_test.sv
module touch_swipe_classifier_test;
  import tsc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [TYPE_W-1:0]         etype;
    logic [CODE_W-1:0]         ecode;
    logic signed [VALUE_W-1:0] evalue;
  } touch_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsc_event_if   evt_ch ();
  tsc_gesture_if res_ch ();
  tsc_cfg_if     cfg_ch ();

  touch_swipe_classifier uut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_event_t event_queue[$];
  gesture_t     gesture_queue[$];

  // shadow of the block's registers and touch tracking state
  cfg_t               settings;
  logic [COORD_W-1:0] start_x, start_y, last_x, last_y;
  bit                 x_seen, y_seen;

  int  errors;
  bit  quiet;
  bit  send_pause;
  int  hold_requests, hold_served, hold_left;
  int  idle_cycles;
  gesture_t     predicted;
  gesture_t     wanted;
  touch_event_t next_event;

  function automatic bit classify_event(input logic [TYPE_W-1:0] etype,
                                        input logic [CODE_W-1:0] ecode,
                                        input logic signed [VALUE_W-1:0] evalue,
                                        output gesture_t g);
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] dx, dy;
    bit                 release_seen, in_rect;
    if (evalue < 0)
      c = '0;
    else if (evalue > 32'sd65535)
      c = 16'hFFFF;
    else
      c = evalue[COORD_W-1:0];
    g = G_RESTART;
    if (etype == EV_ABS && ecode == CODE_X) begin
      if (!x_seen) begin
        start_x = c;
        x_seen = 1'b1;
      end
      last_x = c;
    end
    if (etype == EV_ABS && ecode == CODE_Y) begin
      if (!y_seen) begin
        start_y = c;
        y_seen = 1'b1;
      end
      last_y = c;
    end
    release_seen = (etype == EV_KEY && ecode == CODE_TOUCH && evalue == 0) ||
                   (etype == EV_ABS && ecode == CODE_PRESSURE && evalue == 0);
    if (!release_seen)
      return 1'b0;
    dx = !x_seen ? '0 : (last_x > start_x) ? last_x - start_x : start_x - last_x;
    dy = !y_seen ? '0 : (last_y > start_y) ? last_y - start_y : start_y - last_y;
    if (dx < settings.tap_threshold && dy < settings.tap_threshold) begin
      // bounds in 17 bits so the rectangle edge never wraps
      in_rect = x_seen && y_seen &&
                start_x >= settings.undo_left &&
                {1'b0, start_x} < {1'b0, settings.undo_left} + {1'b0, settings.undo_width} &&
                start_y >= settings.undo_top &&
                {1'b0, start_y} < {1'b0, settings.undo_top} + {1'b0, settings.undo_height};
      g = in_rect ? G_UNDO : G_RESTART;
    end else if ({1'b0, dx} >= {dy, 1'b0}) begin
      g = (x_seen && last_x > start_x) ? G_RIGHT : G_LEFT;
    end else if ({1'b0, dy} >= {dx, 1'b0}) begin
      g = (y_seen && last_y > start_y) ? G_DOWN : G_UP;
    end else begin
      // ambiguous: drop the start points, keep the latest ones
      start_x = '0;
      start_y = '0;
      x_seen = 1'b0;
      y_seen = 1'b0;
      return 1'b0;
    end
    start_x = '0;
    start_y = '0;
    last_x = '0;
    last_y = '0;
    x_seen = 1'b0;
    y_seen = 1'b0;
    return 1'b1;
  endfunction

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      evt_ch.valid <= 1'b0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (classify_event(evt_ch.event_type, evt_ch.event_code, evt_ch.event_value,
                           predicted))
          gesture_queue.push_back(predicted);
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (event_queue.size() != 0 && !send_pause &&
            (quiet || $urandom_range(99) >= 11)) begin
          next_event = event_queue.pop_front();
          evt_ch.valid       <= 1'b1;
          evt_ch.event_type  <= next_event.etype;
          evt_ch.event_code  <= next_event.ecode;
          evt_ch.event_value <= next_event.evalue;
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // gesture monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (gesture_queue.size() == 0) begin
          $error("gesture: no request pending, actual %0d", res_ch.gesture);
          errors++;
        end else begin
          wanted = gesture_queue.pop_front();
          if (res_ch.gesture !== wanted) begin
            $error("gesture: expected %0d, actual %0d", wanted, res_ch.gesture);
            errors++;
          end
        end
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("touch_swipe_classifier test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_event(input logic [TYPE_W-1:0] etype, input logic [CODE_W-1:0] ecode,
                            input int evalue);
    touch_event_t e;
    e.etype = etype;
    e.ecode = ecode;
    e.evalue = evalue;
    event_queue.push_back(e);
  endtask

  task automatic push_noise();
    case ($urandom_range(3))
      0: push_event(EV_KEY, CODE_TOUCH, 1);
      1: push_event(EV_ABS, CODE_PRESSURE, $urandom_range(255, 1));
      default: push_event(TYPE_W'($urandom_range(31)), CODE_W'($urandom_range(1023)),
                          int'($urandom));
    endcase
  endtask

  task automatic push_coord(input logic [CODE_W-1:0] ecode, input int v);
    if ($urandom_range(7) == 0)
      push_noise();
    push_event(EV_ABS, ecode, v);
  endtask

  // one touch: start point, a few moves, then usually a release
  task automatic push_touch(output int pushed);
    int  thr, sx, sy, ox, oy, main_d, cross_d, steps, hi, k, before_cnt;
    bit  has_x, has_y, x_major;
    before_cnt = event_queue.size();
    thr = int'(settings.tap_threshold);
    sx = $urandom_range(65535);
    sy = $urandom_range(65535);
    if (settings.undo_width != 0 && settings.undo_height != 0 && $urandom_range(3) == 0) begin
      hi = settings.undo_left + settings.undo_width - 1;
      sx = $urandom_range(hi > 65535 ? 65535 : hi, settings.undo_left);
      hi = settings.undo_top + settings.undo_height - 1;
      sy = $urandom_range(hi > 65535 ? 65535 : hi, settings.undo_top);
    end
    x_major = 1'($urandom_range(1));
    main_d = $urandom_range(65535);
    case ($urandom_range(9))
      0, 1, 2: begin
        ox = (thr > 0) ? $urandom_range(thr - 1) : 0;
        oy = (thr > 0) ? $urandom_range(thr - 1) : 0;
      end
      3, 4, 5, 6: begin
        cross_d = ($urandom_range(3) == 0) ? main_d / 2 : main_d / $urandom_range(12, 2);
        ox = x_major ? main_d : cross_d;
        oy = x_major ? cross_d : main_d;
      end
      7, 8: begin
        cross_d = main_d * $urandom_range(95, 55) / 100;
        ox = x_major ? main_d : cross_d;
        oy = x_major ? cross_d : main_d;
      end
      default: begin
        ox = $urandom_range(200000) - 100000;
        oy = $urandom_range(200000) - 100000;
      end
    endcase
    if ($urandom_range(1))
      ox = -ox;
    if ($urandom_range(1))
      oy = -oy;
    has_x = $urandom_range(9) != 0;
    has_y = $urandom_range(9) != 0;
    steps = $urandom_range(3);
    for (k = 0; k <= steps + 1; k++) begin
      if (has_x)
        push_coord(CODE_X, sx + ox * k / (steps + 1));
      if (has_y)
        push_coord(CODE_Y, sy + oy * k / (steps + 1));
    end
    case ($urandom_range(9))
      0: ;
      1, 2, 3, 4: push_event(EV_KEY, CODE_TOUCH, 0);
      default: push_event(EV_ABS, CODE_PRESSURE, 0);
    endcase
    pushed = event_queue.size() - before_cnt;
  endtask

  task automatic push_touches(input int n);
    int cnt, added;
    cnt = 0;
    while (cnt < n) begin
      push_touch(added);
      cnt += added;
    end
  endtask

  task automatic wait_drain();
    while (event_queue.size() != 0 || evt_ch.valid || gesture_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TAP_THRESHOLD: settings.tap_threshold = data;
      REG_UNDO_LEFT:     settings.undo_left = data;
      REG_UNDO_TOP:      settings.undo_top = data;
      REG_UNDO_WIDTH:    settings.undo_width = data;
      REG_UNDO_HEIGHT:   settings.undo_height = data;
      default: ;
    endcase
  endtask

  task automatic program_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] left,
                                  input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] w,
                                  input logic [CFG_W-1:0] h, input bit junk);
    @(posedge clk);
    write_reg(REG_TAP_THRESHOLD, thr);
    write_reg(REG_UNDO_LEFT, left);
    write_reg(REG_UNDO_TOP, top);
    write_reg(REG_UNDO_WIDTH, w);
    write_reg(REG_UNDO_HEIGHT, h);
    // indexes past the last register must be ignored
    if (junk) begin
      write_reg(3'd5, CFG_W'($urandom));
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, CFG_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    @(negedge clk);
    push_touches(n);
    @(negedge clk);
    wait_drain();
    @(negedge clk);
  endtask

  initial begin
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    errors = 0;
    quiet = 1'b0;
    send_pause = 1'b0;
    hold_requests = 0;
    hold_served = 0;
    settings = '0;
    settings.tap_threshold = TAP_THRESHOLD_RESET;
    start_x = '0;
    start_y = '0;
    last_x = '0;
    last_y = '0;
    x_seen = 1'b0;
    y_seen = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    @(negedge clk);
    push_event(EV_KEY, CODE_TOUCH, 0);
    push_event(EV_ABS, CODE_X, -5);
    push_event(EV_ABS, CODE_Y, 70000);
    push_event(EV_ABS, CODE_X, 100);
    push_event(EV_ABS, CODE_PRESSURE, 0);
    push_event(EV_ABS, CODE_X, 32'h7FFF_FFFF);
    push_event(EV_ABS, CODE_X, 32'h8000_0000);
    push_event(EV_KEY, CODE_TOUCH, 0);
    push_event(EV_ABS, CODE_Y, 10);
    push_event(EV_ABS, CODE_Y, 500);
    push_event(EV_ABS, CODE_PRESSURE, 0);
    push_event(EV_ABS, CODE_Y, 500);
    push_event(EV_ABS, CODE_Y, 10);
    push_event(EV_KEY, CODE_TOUCH, 0);
    // ambiguous move, then a release with only stale latest points
    push_event(EV_ABS, CODE_X, 0);
    push_event(EV_ABS, CODE_Y, 0);
    push_event(EV_ABS, CODE_X, 300);
    push_event(EV_ABS, CODE_Y, 300);
    push_event(EV_KEY, CODE_TOUCH, 0);
    push_event(EV_KEY, CODE_TOUCH, 0);
    push_event(EV_KEY, CODE_TOUCH, 1);
    push_event(EV_ABS, CODE_PRESSURE, 7);
    push_event(5'd2, CODE_X, 5);
    push_event(EV_ABS, CODE_TOUCH, 0);
    push_event(EV_KEY, CODE_PRESSURE, 0);
    @(negedge clk);
    wait_drain();

    // no idling on either side
    @(negedge clk);
    quiet = 1'b1;
    random_phase(200);
    quiet = 1'b0;

    // receiver holds off while a burst of releases keeps coming
    quiet = 1'b1;
    hold_requests = hold_requests + 1;
    repeat (40) push_event(EV_KEY, CODE_TOUCH, 0);
    @(negedge clk);
    wait_drain();
    @(negedge clk);
    quiet = 1'b0;

    // zero threshold: no taps, zero deltas give left
    program_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    push_event(EV_ABS, CODE_PRESSURE, 0);
    push_touches(100);
    while (event_queue.size() > 40) @(negedge clk);
    send_pause = 1'b1;
    while (gesture_queue.size() != 0 || evt_ch.valid) @(negedge clk);
    repeat (5) @(negedge clk);
    send_pause = 1'b0;
    random_phase(100);

    // maximum threshold, rectangle at the far corner
    program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_event(EV_ABS, CODE_X, 65535);
    push_event(EV_ABS, CODE_Y, 65535);
    push_event(EV_KEY, CODE_TOUCH, 0);
    push_event(EV_ABS, CODE_X, 65534);
    push_event(EV_ABS, CODE_Y, 65535);
    push_event(EV_KEY, CODE_TOUCH, 0);
    random_phase(150);

    // zero width disables the rectangle
    program_settings(CFG_W'($urandom_range(2000, 10)), CFG_W'($urandom), CFG_W'($urandom),
                     16'd0, CFG_W'($urandom_range(65535, 1)), 1'b1);
    random_phase(200);

    program_settings(CFG_W'($urandom_range(500, 50)), CFG_W'($urandom_range(30000)),
                     CFG_W'($urandom_range(30000)), CFG_W'($urandom_range(30000, 1)),
                     CFG_W'($urandom_range(30000, 1)), 1'b0);
    random_phase(350);

    program_settings(TAP_THRESHOLD_RESET, 16'd0, 16'd0, 16'd1, 16'd1, 1'b0);
    push_event(EV_ABS, CODE_X, 0);
    push_event(EV_ABS, CODE_Y, -1);
    push_event(EV_ABS, CODE_PRESSURE, 0);
    random_phase(150);

    if (errors == 0)
      $display("touch_swipe_classifier test passed");
    else
      $display("touch_swipe_classifier test failed");
    $finish;
  end

endmodule
